// ===== design/psfc_pkg.sv =====
package psfc_pkg;

   // Conversion selected by the mode register.
   typedef enum logic [3:0] {
      MODE_U8_TO_F32  = 4'd0,
      MODE_S16_TO_F32 = 4'd1,
      MODE_S24_TO_F32 = 4'd2,
      MODE_S32_TO_F32 = 4'd3,
      MODE_S64_TO_F32 = 4'd4,
      MODE_F64_TO_F32 = 4'd5,
      MODE_F32_TO_U8  = 4'd6,
      MODE_F32_TO_S16 = 4'd7,
      MODE_F32_TO_S32 = 4'd8,
      MODE_S24_TO_U8  = 4'd9,
      MODE_S24_TO_S16 = 4'd10,
      MODE_U8_TO_S16  = 4'd11,
      MODE_U8_TO_S32  = 4'd12,
      MODE_S16_TO_S32 = 4'd13,
      MODE_S24_TO_S32 = 4'd14
   } mode_type;

   // Load enables of the internal pipeline stages one to five.
   typedef struct packed {
      logic st1;
      logic st2;
      logic st3;
      logic st4;
      logic st5;
   } stage_en_type;

   localparam int SAMPLE_WIDTH = 64;
   localparam int WORD_WIDTH   = 32;

   // Clamp limits of the float to integer conversions, as magnitudes.
   localparam logic [31:0] U8_POS_LIMIT  = 32'd127;
   localparam logic [31:0] U8_NEG_LIMIT  = 32'd128;
   localparam logic [31:0] S16_POS_LIMIT = 32'd32767;
   localparam logic [31:0] S16_NEG_LIMIT = 32'd32768;
   localparam logic [31:0] S32_POS_LIMIT = 32'd2147483520;
   localparam logic [31:0] S32_NEG_LIMIT = 32'h8000_0000;

endpackage

// ===== design/psfc_to_float.sv =====
module psfc_to_float
   import psfc_pkg::*;
(
   input  logic                    clock,
   input  stage_en_type            en,
   input  mode_type                mode,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   output logic [WORD_WIDTH-1:0]   word
);

   // Stage one: sign, magnitude and exponent offset.
   logic               sign1_in, zero1_in, inf1_in;
   logic [63:0]        mag1_in;
   logic signed [12:0] eoff1_in;
   logic [63:0]        sv;
   logic               is_int;

   logic               sign1_ff, zero1_ff, inf1_ff;
   logic [63:0]        mag1_ff;
   logic signed [12:0] eoff1_ff;

   always_comb begin
      sv       = '0;
      eoff1_in = '0;
      is_int   = 1'b1;
      sign1_in = 1'b0;
      zero1_in = 1'b0;
      inf1_in  = 1'b0;
      mag1_in  = '0;
      unique case (mode)
         MODE_U8_TO_F32: begin
            sv       = {{56{~sample[7]}}, ~sample[7], sample[6:0]};
            eoff1_in = 13'sd56;
         end
         MODE_S16_TO_F32: begin
            sv       = {{48{sample[15]}}, sample[15:0]};
            eoff1_in = 13'sd48;
         end
         MODE_S24_TO_F32: begin
            sv       = {{40{sample[23]}}, sample[23:0]};
            eoff1_in = 13'sd40;
         end
         MODE_S32_TO_F32: begin
            sv       = {{32{sample[31]}}, sample[31:0]};
            eoff1_in = 13'sd32;
         end
         MODE_S64_TO_F32: begin
            sv       = sample;
            eoff1_in = 13'sd0;
         end
         default: begin
            is_int = 1'b0;
         end
      endcase
      if (is_int) begin
         sign1_in = sv[63];
         mag1_in  = sv[63] ? (~sv + 64'd1) : sv;
         zero1_in = (sv == '0);
      end else begin
         // Double input: the hidden bit sits at the top, so no shift is needed.
         sign1_in = sample[63];
         mag1_in  = {1'b1, sample[51:0], 11'b0};
         eoff1_in = $signed({2'b00, sample[62:52]}) - 13'sd1023;
         if (sample[62:52] == '1) begin
            if (sample[51:0] != '0) begin
               zero1_in = 1'b1;
               sign1_in = 1'b0;
            end else begin
               inf1_in = 1'b1;
            end
         end else if (sample[62:52] == '0) begin
            zero1_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.st1) begin
         sign1_ff <= sign1_in;
         zero1_ff <= zero1_in;
         inf1_ff  <= inf1_in;
         mag1_ff  <= mag1_in;
         eoff1_ff <= eoff1_in;
      end
   end

   // Stage two: leading zero count, byte by byte.
   logic [7:0] nz;
   logic [2:0] lzb [8];
   logic [5:0] lzc2_in;

   logic               sign2_ff, zero2_ff, inf2_ff;
   logic [63:0]        mag2_ff;
   logic signed [12:0] eoff2_ff;
   logic [5:0]         lzc2_ff;

   always_comb begin
      lzc2_in = '0;
      for (int b = 0; b < 8; b++) begin
         nz[b]  = |mag1_ff[8*b +: 8];
         lzb[b] = 3'd7;
         for (int i = 0; i < 8; i++) begin
            if (mag1_ff[8*b + i]) begin
               lzb[b] = 3'(7 - i);
            end
         end
      end
      for (int b = 0; b < 8; b++) begin
         if (nz[b]) begin
            lzc2_in = {3'(7 - b), lzb[b]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.st2) begin
         sign2_ff <= sign1_ff;
         zero2_ff <= zero1_ff;
         inf2_ff  <= inf1_ff;
         mag2_ff  <= mag1_ff;
         eoff2_ff <= eoff1_ff;
         lzc2_ff  <= lzc2_in;
      end
   end

   // Stage three: normalize.
   logic [63:0]        norm3_in;
   logic signed [12:0] e3_in;

   logic               sign3_ff, zero3_ff, inf3_ff;
   logic [63:0]        norm3_ff;
   logic signed [12:0] e3_ff;

   always_comb begin
      norm3_in = mag2_ff << lzc2_ff;
      e3_in    = eoff2_ff - $signed({7'b0, lzc2_ff});
   end

   always_ff @(posedge clock) begin
      if (en.st3) begin
         sign3_ff <= sign2_ff;
         zero3_ff <= zero2_ff;
         inf3_ff  <= inf2_ff;
         norm3_ff <= norm3_in;
         e3_ff    <= e3_in;
      end
   end

   // Stage four: round to the 53 bit double significand.
   logic               inc53;
   logic [53:0]        sum53;
   logic [52:0]        m4_in;
   logic signed [12:0] e4_in;

   logic               sign4_ff, zero4_ff, inf4_ff;
   logic [52:0]        m4_ff;
   logic signed [12:0] e4_ff;

   always_comb begin
      inc53 = norm3_ff[10] & ((|norm3_ff[9:0]) | norm3_ff[11]);
      sum53 = {1'b0, norm3_ff[63:11]} + 54'(inc53);
      if (sum53[53]) begin
         m4_in = sum53[53:1];
         e4_in = e3_ff + 13'sd1;
      end else begin
         m4_in = sum53[52:0];
         e4_in = e3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.st4) begin
         sign4_ff <= sign3_ff;
         zero4_ff <= zero3_ff;
         inf4_ff  <= inf3_ff;
         m4_ff    <= m4_in;
         e4_ff    <= e4_in;
      end
   end

   // Stage five: single exponent, denormalizing shift for tiny values.
   logic signed [12:0] be, sh;
   logic               normal, ovf;
   logic [5:0]         sh_c;
   logic [107:0]       wide;
   logic [7:0]         expf5_in;

   logic               sign5_ff, zero5_ff, inf5_ff, drop5_ff;
   logic [52:0]        m5_ff;
   logic [7:0]         expf5_ff;

   always_comb begin
      be       = e4_ff + 13'sd127;
      normal   = (be > 13'sd0);
      ovf      = (be >= 13'sd255);
      sh       = 13'sd1 - be;
      sh_c     = normal ? 6'd0 : ((sh > 13'sd55) ? 6'd55 : sh[5:0]);
      wide     = {m4_ff, 55'b0} >> sh_c;
      expf5_in = normal ? be[7:0] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (en.st5) begin
         sign5_ff <= sign4_ff;
         zero5_ff <= zero4_ff;
         inf5_ff  <= inf4_ff | ovf;
         drop5_ff <= |wide[54:0];
         m5_ff    <= wide[107:55];
         expf5_ff <= expf5_in;
      end
   end

   // Round to 24 bits and pack; a carry runs into the exponent on its own.
   logic        inc24;
   logic [30:0] body;

   always_comb begin
      inc24 = m5_ff[28] & ((|m5_ff[27:0]) | drop5_ff | m5_ff[29]);
      body  = {expf5_ff, m5_ff[51:29]} + 31'(inc24);
      if (zero5_ff) begin
         word = {sign5_ff, 31'b0};
      end else if (inf5_ff) begin
         word = {sign5_ff, 8'hFF, 23'b0};
      end else begin
         word = {sign5_ff, body};
      end
   end

endmodule

// ===== design/psfc_from_float.sv =====
module psfc_from_float
   import psfc_pkg::*;
(
   input  logic                  clock,
   input  stage_en_type          en,
   input  mode_type              mode,
   input  logic [31:0]           sample,
   output logic [WORD_WIDTH-1:0] word
);

   // Stage one: unpack, scale exponent, NaN reads as zero.
   logic              nan0;
   logic              sign1_in, inf1_in;
   logic [23:0]       m1_in;
   logic signed [9:0] es1_in, k0, eu0;

   logic              sign1_ff, inf1_ff;
   logic [23:0]       m1_ff;
   logic signed [9:0] es1_ff;

   always_comb begin
      nan0     = (sample[30:23] == '1) && (sample[22:0] != '0);
      inf1_in  = (sample[30:23] == '1) && (sample[22:0] == '0);
      sign1_in = nan0 ? 1'b0 : sample[31];
      m1_in    = nan0 ? 24'd0 : {(sample[30:23] != '0), sample[22:0]};
      // A NaN takes the smallest exponent so that it can never saturate.
      eu0      = ((sample[30:23] == '0) || nan0) ? -10'sd126
                                       : ($signed({2'b00, sample[30:23]}) - 10'sd127);
      unique case (mode)
         MODE_F32_TO_U8:  k0 = 10'sd7;
         MODE_F32_TO_S16: k0 = 10'sd15;
         default:         k0 = 10'sd31;
      endcase
      es1_in = eu0 + k0;
   end

   always_ff @(posedge clock) begin
      if (en.st1) begin
         sign1_ff <= sign1_in;
         inf1_ff  <= inf1_in;
         m1_ff    <= m1_in;
         es1_ff   <= es1_in;
      end
   end

   // Stage two: fixed point with 26 fraction bits plus a sticky bit.
   logic signed [9:0] t1, nt1;
   logic [5:0]        shl;
   logic [4:0]        shr;
   logic [56:0]       a2_in;
   logic              sticky2_in, sat2_in;

   logic              sign2_ff, sticky2_ff, sat2_ff;
   logic [56:0]       a2_ff;

   always_comb begin
      t1         = es1_ff + 10'sd3;
      nt1        = -t1;
      shl        = '0;
      shr        = '0;
      a2_in      = '0;
      sticky2_in = 1'b0;
      sat2_in    = inf1_ff |
                   (es1_ff >= ((mode == MODE_F32_TO_S32) ? 10'sd31 : 10'sd16));
      if (!t1[9]) begin
         shl   = (t1 > 10'sd33) ? 6'd33 : t1[5:0];
         a2_in = 57'(m1_ff) << shl;
      end else if (nt1 > 10'sd24) begin
         sticky2_in = |m1_ff;
      end else begin
         shr        = nt1[4:0];
         a2_in      = 57'(m1_ff >> shr);
         sticky2_in = |(m1_ff & ~('1 << shr));
      end
   end

   always_ff @(posedge clock) begin
      if (en.st2) begin
         sign2_ff   <= sign1_ff;
         sticky2_ff <= sticky2_in;
         sat2_ff    <= sat2_in;
         a2_ff      <= a2_in;
      end
   end

   // Stage three: add one half and smear the leading one downward.
   logic [42:0] y3_in, s3_in;

   logic        sign3_ff, sticky3_ff, sat3_ff;
   logic [42:0] y3_ff, s3_ff;
   logic [30:0] t8_3_ff;

   always_comb begin
      y3_in = {1'b0, a2_ff[41:0]} + (43'd1 << 25);
      s3_in = y3_in;
      s3_in = s3_in | (s3_in >> 1);
      s3_in = s3_in | (s3_in >> 2);
      s3_in = s3_in | (s3_in >> 4);
      s3_in = s3_in | (s3_in >> 8);
      s3_in = s3_in | (s3_in >> 16);
      s3_in = s3_in | (s3_in >> 32);
   end

   always_ff @(posedge clock) begin
      if (en.st3) begin
         sign3_ff   <= sign2_ff;
         sticky3_ff <= sticky2_ff;
         sat3_ff    <= sat2_ff;
         y3_ff      <= y3_in;
         s3_ff      <= s3_in;
         t8_3_ff    <= a2_ff[56:26];
      end
   end

   // Stage four: round the sum to 24 significant bits, truncate, clamp.
   logic [42:0] mask, half, lsbq;
   logic        up;
   logic [43:0] r;
   logic [31:0] t4, pos_lim, neg_lim, lim, mag4_in;

   logic        sign4_ff;
   logic [31:0] mag4_ff;

   always_comb begin
      mask = s3_ff >> 24;
      half = mask ^ (s3_ff >> 25);
      lsbq = (s3_ff >> 23) ^ mask;
      up   = (|(y3_ff & half)) &
             ((|(y3_ff & mask & ~half)) | sticky3_ff | (|(y3_ff & lsbq)));
      r    = {1'b0, y3_ff & ~mask} + (up ? {1'b0, lsbq} : 44'd0);
      t4   = {14'b0, r[43:26]};
      unique case (mode)
         MODE_F32_TO_U8: begin
            pos_lim = U8_POS_LIMIT;
            neg_lim = U8_NEG_LIMIT;
         end
         MODE_F32_TO_S16: begin
            pos_lim = S16_POS_LIMIT;
            neg_lim = S16_NEG_LIMIT;
         end
         default: begin
            pos_lim = S32_POS_LIMIT;
            neg_lim = S32_NEG_LIMIT;
            t4      = {1'b0, t8_3_ff};
         end
      endcase
      lim = sign3_ff ? neg_lim : pos_lim;
      if (sat3_ff || (t4 > lim)) begin
         mag4_in = lim;
      end else begin
         mag4_in = t4;
      end
   end

   always_ff @(posedge clock) begin
      if (en.st4) begin
         sign4_ff <= sign3_ff;
         mag4_ff  <= mag4_in;
      end
   end

   // Stage five: apply the sign and format the word.
   logic [31:0] n5;
   logic [31:0] word5_in;
   logic [31:0] word5_ff;

   always_comb begin
      n5 = sign4_ff ? (~mag4_ff + 32'd1) : mag4_ff;
      if (mode == MODE_F32_TO_U8) begin
         word5_in = {24'b0, n5[7:0] + 8'h80};
      end else begin
         word5_in = n5;
      end
   end

   always_ff @(posedge clock) begin
      if (en.st5) begin
         word5_ff <= word5_in;
      end
   end

   assign word = word5_ff;

endmodule

// ===== design/pcm_sample_format_converter.sv =====
// Channel   Ports                               Direction  Handshake
// request   req_sample_bits, req_last_in        in         req_valid / req_stall
// response  rsp_result_word, rsp_last_out       out        rsp_valid / rsp_stall
// config    csr_write_data                      in         csr_write_enable
//
// A request moves through seven register stages, and one request can be taken
// every cycle unless a response stall has left every stage full.
// The stage count is set by the float path: leading zero count, normalize, double
// rounding, denormalizing shift and final single rounding each take a stage.
// Reset is synchronous and active high; it empties the pipeline and sets the
// mode to u8 to f32. A response stall holds each full stage with no empty stage
// ahead of it and lets empty stages fill, so no request is lost or repeated.
module pcm_sample_format_converter
   import psfc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_bits,
   input  logic                    req_last_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [WORD_WIDTH-1:0]   rsp_result_word,
   output logic                    rsp_last_out,
   input  logic                    csr_write_enable,
   input  logic [3:0]              csr_write_data
);

   // The user must change the mode register only while the pipeline is empty;
   // the block does not enforce it, and every stage reads the register directly.
   mode_type mode_ff, mode_in;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write_enable) begin
         mode_in = mode_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_U8_TO_F32;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Pipeline control. A stage is open when it is empty or its contents move
   // on in this cycle; a stage loads when the stage before it is full and it
   // is open.
   logic [6:0] valid_ff, valid_in;
   logic [6:0] open_w, move, leaving;
   stage_en_type en;

   always_comb begin
      open_w[6] = !valid_ff[6] || !rsp_stall;
      for (int i = 5; i >= 0; i--) begin
         open_w[i] = !valid_ff[i] || open_w[i+1];
      end
      move[0] = req_valid && open_w[0];
      for (int i = 1; i < 7; i++) begin
         move[i] = valid_ff[i-1] && open_w[i];
      end
      for (int i = 0; i < 6; i++) begin
         leaving[i] = move[i+1];
      end
      leaving[6] = !rsp_stall;
      valid_in   = move | (valid_ff & ~leaving);
      en.st1     = move[1];
      en.st2     = move[2];
      en.st3     = move[3];
      en.st4     = move[4];
      en.st5     = move[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !open_w[0];
   assign rsp_valid = valid_ff[6];

   // Stage zero holds the request as taken.
   logic [SAMPLE_WIDTH-1:0] sample0_ff;
   logic                    last_ff [6];

   always_ff @(posedge clock) begin
      if (move[0]) begin
         sample0_ff <= req_sample_bits;
         last_ff[0] <= req_last_in;
      end
      for (int i = 1; i < 6; i++) begin
         if (move[i]) begin
            last_ff[i] <= last_ff[i-1];
         end
      end
   end

   // The integer to integer pairs are plain bit moves, done in stage one and
   // then carried along to line up with the float paths.
   logic [31:0] int1_in;
   logic [31:0] int_ff [1:5];

   always_comb begin
      unique case (mode_ff)
         MODE_S24_TO_U8:  int1_in = {24'b0, sample0_ff[23:16] ^ 8'h80};
         MODE_S24_TO_S16: int1_in = {{16{sample0_ff[23]}}, sample0_ff[23:8]};
         MODE_U8_TO_S16:  int1_in = {{16{~sample0_ff[7]}}, ~sample0_ff[7],
                                     sample0_ff[6:0], 8'b0};
         MODE_U8_TO_S32:  int1_in = {{24{~sample0_ff[7]}}, ~sample0_ff[7],
                                     sample0_ff[6:0]};
         MODE_S16_TO_S32: int1_in = {{16{sample0_ff[15]}}, sample0_ff[15:0]};
         MODE_S24_TO_S32: int1_in = {{8{sample0_ff[23]}}, sample0_ff[23:0]};
         default:         int1_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (move[1]) begin
         int_ff[1] <= int1_in;
      end
      for (int i = 2; i < 6; i++) begin
         if (move[i]) begin
            int_ff[i] <= int_ff[i-1];
         end
      end
   end

   // Integer and double samples to single precision.
   logic [WORD_WIDTH-1:0] float_word;

   psfc_to_float u_to_float (
      .clock  (clock),
      .en     (en),
      .mode   (mode_ff),
      .sample (sample0_ff),
      .word   (float_word)
   );

   // Single precision to u8, s16 and s32.
   logic [WORD_WIDTH-1:0] fixed_word;

   psfc_from_float u_from_float (
      .clock  (clock),
      .en     (en),
      .mode   (mode_ff),
      .sample (sample0_ff[31:0]),
      .word   (fixed_word)
   );

   // Output register: pick the path that the mode names.
   logic [WORD_WIDTH-1:0] result_in;
   logic [WORD_WIDTH-1:0] rsp_result_word_ff;
   logic                  rsp_last_out_ff;

   always_comb begin
      case (mode_ff) inside
         [MODE_U8_TO_F32:MODE_F64_TO_F32]:                 result_in = float_word;
         MODE_F32_TO_U8, MODE_F32_TO_S16, MODE_F32_TO_S32: result_in = fixed_word;
         default:                                          result_in = int_ff[5];
      endcase
   end

   always_ff @(posedge clock) begin
      if (move[6]) begin
         rsp_result_word_ff <= result_in;
         rsp_last_out_ff    <= last_ff[5];
      end
   end

   assign rsp_result_word = rsp_result_word_ff;
   assign rsp_last_out    = rsp_last_out_ff;

   // With the response side free, every stage drains and the input is open.
   assert property (@(posedge clock) disable iff (reset) !rsp_stall |-> !req_stall)
      else $error("request stalled while the response side is free");

   // The input is only stalled when the first stage is holding a request.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> valid_ff[0])
      else $error("request stalled with the first stage empty");

   // A response taken with nothing behind it leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !valid_ff[5]) |=> !rsp_valid)
      else $error("response repeated after it was taken");

endmodule
